// ===== hdl/tvp_pkg.sv =====
// Shared types and constants for the video test pattern pixel core.
package tvp_pkg;

    // Fixed field widths
    localparam int PIX_W     = 11;
    localparam int IDX_W     = 8;
    localparam int CFG_W     = 12;
    localparam int CFG_IDX_W = 2;

    // Gradient scale: x * 256 is x shifted by this many bits
    localparam int GRAD_SHIFT = 8;

    // Palette codes
    localparam logic [IDX_W-1:0] IDX_WHITE = 8'hFF;
    localparam logic [IDX_W-1:0] IDX_OFF   = 8'h00;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_HEIGHT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_INDEXED_MODE = 2'd2;

    // Reset values of the configuration registers
    localparam logic [CFG_W-1:0] RST_FRAME_WIDTH  = 12'd320;
    localparam logic [CFG_W-1:0] RST_FRAME_HEIGHT = 12'd288;

    // Per-pixel data that rides along the divider chain
    typedef struct packed {
        logic [PIX_W-1:0] y;
        logic             oof;
        logic             use_pre;
        logic [IDX_W-1:0] pre_idx;
    } t_side;

endpackage

// ===== hdl/tvp_front.sv =====
// Input stage: range checks, border, fallback pattern and divider operands.
module tvp_front #(
    parameter int DEN_W = 12,
    parameter int STEPS = 12
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_en,
    input  logic                      i_valid,
    input  logic [tvp_pkg::PIX_W-1:0] i_x,
    input  logic [tvp_pkg::PIX_W-1:0] i_y,
    input  logic [DEN_W-1:0]          i_w,
    input  logic [DEN_W-1:0]          i_h,
    input  logic                      i_indexed,
    output logic                      o_valid,
    output tvp_pkg::t_side            o_side,
    output logic [DEN_W-1:0]          o_rem_d,
    output logic [STEPS-1:0]          o_num_d,
    output logic [DEN_W-1:0]          o_rem_g,
    output logic [STEPS-1:0]          o_num_g
);
    import tvp_pkg::*;

    localparam int CW = (STEPS > PIX_W) ? STEPS : PIX_W;
    localparam int PW = PIX_W + DEN_W;
    localparam int NW = STEPS + DEN_W;
    localparam int GW = PIX_W + GRAD_SHIFT;

    logic [CW-1:0]    x_c, y_c, w_c, h_c;
    logic [DEN_W-1:0] h_m1;
    logic [PW-1:0]    prod;
    logic [NW-1:0]    num_d, num_g;
    logic [PIX_W:0]   sum_xy;
    logic             oof, border;
    t_side            n_side;

    logic             r_valid;
    t_side            r_side;
    logic [NW-1:0]    r_num_d, r_num_g;

    // Compare coordinates against the frame size
    always_comb begin
        x_c    = CW'(i_x);
        y_c    = CW'(i_y);
        w_c    = CW'(i_w);
        h_c    = CW'(i_h);
        h_m1   = i_h - DEN_W'(1);
        oof    = (x_c >= w_c) || (y_c >= h_c);
        border = (x_c == '0) || (y_c == '0) ||
                 (x_c == w_c - CW'(1)) || (y_c == h_c - CW'(1));
        sum_xy = {1'b0, i_x} + {1'b0, i_y};
    end

    // Build the two dividends: x*(h-1) for the diagonal, x*256 for the gradient
    always_comb begin
        prod  = PW'(i_x) * PW'(h_m1);
        num_d = NW'(prod);
        num_g = NW'({i_x, {GRAD_SHIFT{1'b0}}});
    end

    // Pick the result where no quotient is needed
    always_comb begin
        n_side.y = i_y;
        n_side.oof = oof;
        n_side.use_pre = oof || !i_indexed || border;
        if (oof) begin
            n_side.pre_idx = IDX_OFF;
        end else if (!i_indexed) begin
            n_side.pre_idx = sum_xy[IDX_W:1];
        end else begin
            n_side.pre_idx = IDX_WHITE;
        end
    end

    // Stage register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_side  <= n_side;
            r_num_d <= num_d;
            r_num_g <= num_g;
        end
    end

    assign o_valid = r_valid;
    assign o_side  = r_side;
    assign o_rem_d = r_num_d[NW-1:STEPS];
    assign o_num_d = r_num_d[STEPS-1:0];
    assign o_rem_g = r_num_g[NW-1:STEPS];
    assign o_num_g = r_num_g[STEPS-1:0];

endmodule

// ===== hdl/tvp_div_cell.sv =====
// One divider cell: a restoring step for both quotients, then a register.
module tvp_div_cell #(
    parameter int DEN_W = 12,
    parameter int STEPS = 12
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_en,
    input  logic             i_valid,
    input  tvp_pkg::t_side   i_side,
    input  logic [DEN_W-1:0] i_den_d,
    input  logic [DEN_W-1:0] i_den_g,
    input  logic [DEN_W-1:0] i_rem_d,
    input  logic [STEPS-1:0] i_num_d,
    input  logic [STEPS-1:0] i_q_d,
    input  logic [DEN_W-1:0] i_rem_g,
    input  logic [STEPS-1:0] i_num_g,
    input  logic [STEPS-1:0] i_q_g,
    output logic             o_valid,
    output tvp_pkg::t_side   o_side,
    output logic [DEN_W-1:0] o_rem_d,
    output logic [STEPS-1:0] o_num_d,
    output logic [STEPS-1:0] o_q_d,
    output logic [DEN_W-1:0] o_rem_g,
    output logic [STEPS-1:0] o_num_g,
    output logic [STEPS-1:0] o_q_g
);
    import tvp_pkg::*;

    logic [DEN_W:0]   trial_d, trial_g, diff_d, diff_g;
    logic             ge_d, ge_g;
    logic [DEN_W-1:0] n_rem_d, n_rem_g;

    logic             r_valid;
    t_side            r_side;
    logic [DEN_W-1:0] r_rem_d, r_rem_g;
    logic [STEPS-1:0] r_num_d, r_num_g, r_q_d, r_q_g;

    // Shift in the next dividend bit and subtract the divisor when it fits
    always_comb begin
        trial_d = {i_rem_d, i_num_d[STEPS-1]};
        trial_g = {i_rem_g, i_num_g[STEPS-1]};
        diff_d  = trial_d - {1'b0, i_den_d};
        diff_g  = trial_g - {1'b0, i_den_g};
        ge_d    = trial_d >= {1'b0, i_den_d};
        ge_g    = trial_g >= {1'b0, i_den_g};
        n_rem_d = ge_d ? diff_d[DEN_W-1:0] : trial_d[DEN_W-1:0];
        n_rem_g = ge_g ? diff_g[DEN_W-1:0] : trial_g[DEN_W-1:0];
    end

    // Hand the partial results to the next cell
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_side  <= i_side;
            r_rem_d <= n_rem_d;
            r_rem_g <= n_rem_g;
            r_num_d <= {i_num_d[STEPS-2:0], 1'b0};
            r_num_g <= {i_num_g[STEPS-2:0], 1'b0};
            r_q_d   <= {i_q_d[STEPS-2:0], ge_d};
            r_q_g   <= {i_q_g[STEPS-2:0], ge_g};
        end
    end

    assign o_valid = r_valid;
    assign o_side  = r_side;
    assign o_rem_d = r_rem_d;
    assign o_num_d = r_num_d;
    assign o_q_d   = r_q_d;
    assign o_rem_g = r_rem_g;
    assign o_num_g = r_num_g;
    assign o_q_g   = r_q_g;

endmodule

// ===== hdl/video_test_pattern_pixel_core.sv =====
// Top level: config registers, front stage, divider cell chain and output register.
// Pipeline: front stage register, then the divider cell chain, then the output register;
//   the divider width STEPS is max(8, width of the clamped frame size).
// Throughput: one pixel per cycle unless stalled; each chain cell resolves one quotient bit.
// A stalled output freezes the whole pipeline and stalls the input side.
// Reset (synchronous, active low) empties the pipeline and loads width 320,
//   height 288 and indexed mode.
module video_test_pattern_pixel_core #(
    parameter int MAX_DIM = 2048
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // pixel request
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  logic [tvp_pkg::PIX_W-1:0]     i_pixel_x,
    input  logic [tvp_pkg::PIX_W-1:0]     i_pixel_y,
    // pattern result
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output logic [tvp_pkg::IDX_W-1:0]     o_pixel_index,
    output logic                          o_out_of_frame,
    // configuration writes
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [tvp_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [tvp_pkg::CFG_W-1:0]     i_cfg_data
);
    import tvp_pkg::*;

    localparam int DIM_RAW = $clog2(MAX_DIM + 1);
    localparam int DIM_W   = (DIM_RAW < CFG_W) ? DIM_RAW : CFG_W;
    localparam int STEPS   = (DIM_W > IDX_W) ? DIM_W : IDX_W;
    localparam int CW      = (STEPS > PIX_W) ? STEPS : PIX_W;

    function automatic logic [DIM_W-1:0] clamp_dim(input logic [CFG_W-1:0] v);
        logic [DIM_W-1:0] res;
        if (int'(v) > MAX_DIM) begin
            res = DIM_W'(MAX_DIM);
        end else begin
            res = DIM_W'(v);
        end
        return res;
    endfunction

    logic [DIM_W-1:0] r_width, r_height;
    logic             r_indexed;
    logic [DIM_W-1:0] den_d, h_m1;
    logic             en;

    logic             valid_c [0:STEPS];
    t_side            side_c  [0:STEPS];
    logic [DIM_W-1:0] rem_d_c [0:STEPS];
    logic [DIM_W-1:0] rem_g_c [0:STEPS];
    logic [STEPS-1:0] num_d_c [0:STEPS];
    logic [STEPS-1:0] num_g_c [0:STEPS];
    logic [STEPS-1:0] q_d_c   [0:STEPS];
    logic [STEPS-1:0] q_g_c   [0:STEPS];

    logic [CW-1:0]    y_c, d_c, hm1_c;
    logic             diag;
    logic [IDX_W-1:0] n_pixel_index;

    logic             r_out_valid;
    logic [IDX_W-1:0] r_pixel_index;
    logic             r_out_of_frame;

    // Store configuration, clamped to the largest frame size
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width   <= clamp_dim(RST_FRAME_WIDTH);
            r_height  <= clamp_dim(RST_FRAME_HEIGHT);
            r_indexed <= 1'b1;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                CFG_FRAME_WIDTH:  r_width   <= clamp_dim(i_cfg_data);
                CFG_FRAME_HEIGHT: r_height  <= clamp_dim(i_cfg_data);
                CFG_INDEXED_MODE: r_indexed <= i_cfg_data[0];
                default:          ;
            endcase
        end
    end

    // Divisors: diagonal uses max(w-1, 1), gradient uses w
    always_comb begin
        den_d = (r_width > DIM_W'(1)) ? r_width - DIM_W'(1) : DIM_W'(1);
        h_m1  = r_height - DIM_W'(1);
    end

    // Advance the whole pipeline unless the output word is held
    assign en         = !(r_out_valid && i_out_stall);
    assign o_in_stall = !en;

    tvp_front #(
        .DEN_W (DIM_W),
        .STEPS (STEPS)
    ) u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_en      (en),
        .i_valid   (i_in_valid),
        .i_x       (i_pixel_x),
        .i_y       (i_pixel_y),
        .i_w       (r_width),
        .i_h       (r_height),
        .i_indexed (r_indexed),
        .o_valid   (valid_c[0]),
        .o_side    (side_c[0]),
        .o_rem_d   (rem_d_c[0]),
        .o_num_d   (num_d_c[0]),
        .o_rem_g   (rem_g_c[0]),
        .o_num_g   (num_g_c[0])
    );

    assign q_d_c[0] = '0;
    assign q_g_c[0] = '0;

    // Chain of divider cells, one quotient bit each
    for (genvar k = 0; k < STEPS; k++) begin : g_cell
        tvp_div_cell #(
            .DEN_W (DIM_W),
            .STEPS (STEPS)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (en),
            .i_valid (valid_c[k]),
            .i_side  (side_c[k]),
            .i_den_d (den_d),
            .i_den_g (r_width),
            .i_rem_d (rem_d_c[k]),
            .i_num_d (num_d_c[k]),
            .i_q_d   (q_d_c[k]),
            .i_rem_g (rem_g_c[k]),
            .i_num_g (num_g_c[k]),
            .i_q_g   (q_g_c[k]),
            .o_valid (valid_c[k+1]),
            .o_side  (side_c[k+1]),
            .o_rem_d (rem_d_c[k+1]),
            .o_num_d (num_d_c[k+1]),
            .o_q_d   (q_d_c[k+1]),
            .o_rem_g (rem_g_c[k+1]),
            .o_num_g (num_g_c[k+1]),
            .o_q_g   (q_g_c[k+1])
        );
    end

    // Check both diagonals and pick the final index
    always_comb begin
        y_c   = CW'(side_c[STEPS].y);
        d_c   = CW'(q_d_c[STEPS]);
        hm1_c = CW'(h_m1);
        diag  = (y_c == d_c) || ((d_c <= hm1_c) && (y_c == hm1_c - d_c));
        if (side_c[STEPS].use_pre) begin
            n_pixel_index = side_c[STEPS].pre_idx;
        end else if (diag) begin
            n_pixel_index = IDX_WHITE;
        end else begin
            n_pixel_index = q_g_c[STEPS][IDX_W-1:0];
        end
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (en) begin
            r_out_valid <= valid_c[STEPS];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_pixel_index  <= n_pixel_index;
            r_out_of_frame <= side_c[STEPS].oof;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_pixel_index  = r_pixel_index;
    assign o_out_of_frame = r_out_of_frame;

    // An out-of-frame word always carries index zero
    a_oof_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_of_frame) |-> (o_pixel_index == IDX_OFF))
        else $error("out-of-frame word with nonzero index");

    // A held output word must stall the input side
    a_stall_back: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |-> o_in_stall)
        else $error("input accepted while output word is held");

    // Reset empties the pipeline
    a_rst_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("output valid right after reset");

    // A held output word keeps its value
    a_hold_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=> ($stable(o_pixel_index) && $stable(o_out_of_frame)))
        else $error("held output word changed");

endmodule

// ===== sim/video_test_pattern_pixel_core_tb.sv =====
// Self-checking testbench for the video test pattern pixel core.
module video_test_pattern_pixel_core_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import tvp_pkg::*;

    localparam int unsigned FRAME_MAX   = 2048;
    localparam int unsigned DRAIN_PAD   = 24;
    localparam int unsigned CYCLE_LIMIT = 400000;
    localparam int unsigned RANDOM_PER_SETTING = 85;

    typedef struct packed {
        logic [IDX_W-1:0] index;
        logic             oof;
    } t_pixel_word;

    typedef struct packed {
        logic [PIX_W-1:0] x;
        logic [PIX_W-1:0] y;
    } t_coord;

    // Pattern predictor and queue of expected pixel words
    class pattern_scoreboard;
        int unsigned   width_reg;
        int unsigned   height_reg;
        bit            indexed;
        t_pixel_word   expected_q[$];
        int unsigned   mismatches;
        int unsigned   compared;

        function new();
            width_reg  = RST_FRAME_WIDTH;
            height_reg = RST_FRAME_HEIGHT;
            indexed    = 1'b1;
            mismatches = 0;
            compared   = 0;
        endfunction

        function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] data);
            case (idx)
                CFG_FRAME_WIDTH:  width_reg  = data;
                CFG_FRAME_HEIGHT: height_reg = data;
                CFG_INDEXED_MODE: indexed    = data[0];
                default: ;
            endcase
        endfunction

        function int unsigned frame_w();
            return (width_reg > FRAME_MAX) ? FRAME_MAX : width_reg;
        endfunction

        function int unsigned frame_h();
            return (height_reg > FRAME_MAX) ? FRAME_MAX : height_reg;
        endfunction

        function t_pixel_word pattern_at(logic [PIX_W-1:0] x, logic [PIX_W-1:0] y);
            int unsigned w, h, xi, yi, dv, d;
            bit          border, diag;
            t_pixel_word r;
            w  = frame_w();
            h  = frame_h();
            xi = x;
            yi = y;
            r.index = IDX_OFF;
            r.oof   = 1'b1;
            if (xi >= w || yi >= h) return r;
            r.oof = 1'b0;
            if (!indexed) begin
                r.index = IDX_W'((xi + yi) >> 1);
            end else begin
                dv     = (w > 1) ? w - 1 : 1;
                d      = (xi * (h - 1)) / dv;
                border = (xi == 0) || (yi == 0) || (xi == w - 1) || (yi == h - 1);
                diag   = (yi == d) || (d <= h - 1 && yi == h - 1 - d);
                if (border || diag) r.index = IDX_WHITE;
                else r.index = IDX_W'((xi << GRAD_SHIFT) / w);
            end
            return r;
        endfunction

        function void note_pixel(t_coord c);
            expected_q.push_back(pattern_at(c.x, c.y));
        endfunction

        function int unsigned pending();
            return expected_q.size();
        endfunction

        task report(string msg);
            $display("mismatch: %s", msg);
            mismatches++;
        endtask

        task check_pixel(t_pixel_word got);
            t_pixel_word want;
            if (expected_q.size() == 0) begin
                report($sformatf("unexpected word index=%0d oof=%0b", got.index, got.oof));
                return;
            end
            want = expected_q.pop_front();
            compared++;
            if (got.index !== want.index)
                report($sformatf("word %0d index got %0d want %0d",
                                 compared, got.index, want.index));
            if (got.oof !== want.oof)
                report($sformatf("word %0d out_of_frame got %0b want %0b",
                                 compared, got.oof, want.oof));
        endtask
    endclass

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 i_in_valid;
    logic                 o_in_stall;
    logic [PIX_W-1:0]     i_pixel_x;
    logic [PIX_W-1:0]     i_pixel_y;
    logic                 o_out_valid;
    logic                 i_out_stall;
    logic [IDX_W-1:0]     o_pixel_index;
    logic                 o_out_of_frame;
    logic                 i_cfg_valid;
    logic                 o_cfg_ready;
    logic [CFG_IDX_W-1:0] i_cfg_index;
    logic [CFG_W-1:0]     i_cfg_data;

    pattern_scoreboard sb = new();
    t_coord            pixel_plan[$];
    int unsigned       cycle_count = 0;
    int unsigned       pixels_sent = 0;

    video_test_pattern_pixel_core #(
        .MAX_DIM(FRAME_MAX)
    ) i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_stall    (o_in_stall),
        .i_pixel_x     (i_pixel_x),
        .i_pixel_y     (i_pixel_y),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_pixel_index (o_pixel_index),
        .o_out_of_frame(o_out_of_frame),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    // Free-running 100 MHz clock
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
    end

    // Abort a hung run
    initial begin
        while (cycle_count < CYCLE_LIMIT) @(posedge i_clk);
        $display("timeout after %0d cycles", cycle_count);
        $display("tb: failure");
        $finish;
    end

    // Check output words, then pick the next stall value by window
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall)
            sb.check_pixel({o_pixel_index, o_out_of_frame});
        case (cycle_count[8:7])
            2'd0: i_out_stall <= 1'b0;
            2'd1: i_out_stall <= ($urandom_range(0, 3) == 0);
            2'd2: i_out_stall <= ($urandom_range(0, 9) < 7);
            default: i_out_stall <= (cycle_count % 3 == 0);
        endcase
    end

    // Hold one pixel request until accepted; valid stays high afterward
    task automatic push_pixel(t_coord c);
        i_in_valid <= 1'b1;
        i_pixel_x  <= c.x;
        i_pixel_y  <= c.y;
        do @(posedge i_clk); while (o_in_stall);
        sb.note_pixel(c);
        pixels_sent++;
    endtask

    // Send the planned pixels in bursts with random gaps
    task automatic send_plan();
        int unsigned burst_left;
        int unsigned gap;
        burst_left = $urandom_range(1, 24);
        while (pixel_plan.size() != 0) begin
            push_pixel(pixel_plan.pop_front());
            burst_left--;
            if (burst_left == 0 && pixel_plan.size() != 0) begin
                gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
                if (gap != 0) begin
                    i_in_valid <= 1'b0;
                    repeat (gap) @(posedge i_clk);
                end
                burst_left = $urandom_range(1, 24);
            end
        end
        i_in_valid <= 1'b0;
    endtask

    // Hold one register write until accepted; caller drops valid
    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        sb.set_reg(idx, data);
    endtask

    // Wait for every expected word, then let the pipeline drain
    task automatic drain();
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (DRAIN_PAD) @(posedge i_clk);
    endtask

    function automatic logic [PIX_W-1:0] clip_coord(int v);
        if (v < 0) return '0;
        if (v > 2047) return '1;
        return PIX_W'(v);
    endfunction

    // Pick one random coordinate, weighted toward the pattern features
    function automatic t_coord pick_pixel();
        int unsigned w, h, kind, xi, d;
        t_coord      c;
        w    = sb.frame_w();
        h    = sb.frame_h();
        kind = $urandom_range(0, 99);
        c.x  = PIX_W'($urandom);
        c.y  = PIX_W'($urandom);
        if (w == 0 || h == 0 || kind >= 90) return c;
        if (kind < 55) begin
            c.x = PIX_W'($urandom_range(0, w - 1));
            c.y = PIX_W'($urandom_range(0, h - 1));
        end else if (kind < 70) begin
            xi  = $urandom_range(0, w - 1);
            d   = (xi * (h - 1)) / ((w > 1) ? w - 1 : 1);
            c.x = PIX_W'(xi);
            c.y = PIX_W'($urandom_range(0, 1) ? d : h - 1 - d);
        end else if (kind < 80) begin
            c.x = PIX_W'($urandom_range(0, w - 1));
            c.y = PIX_W'($urandom_range(0, h - 1));
            case ($urandom_range(0, 3))
                0: c.x = '0;
                1: c.y = '0;
                2: c.x = PIX_W'(w - 1);
                default: c.y = PIX_W'(h - 1);
            endcase
        end else begin
            c.x = clip_coord(int'(w) - 2 + int'($urandom_range(0, 3)));
            c.y = clip_coord(int'(h) - 2 + int'($urandom_range(0, 3)));
        end
        return c;
    endfunction

    // Frame settings: reset values first, then extremes and random sizes
    int unsigned set_w[10] = '{320, 4095, 2, 1, 0, 2048, 640, 0, 0, 320};
    int unsigned set_h[10] = '{288, 4095, 1, 5, 100, 2048, 0, 0, 0, 288};
    bit          set_m[10] = '{1, 1, 1, 1, 1, 0, 0, 1, 0, 1};

    initial begin
        int unsigned n;
        i_rst_n     <= 1'b0;
        i_in_valid  <= 1'b0;
        i_pixel_x   <= '0;
        i_pixel_y   <= '0;
        i_out_stall <= 1'b0;
        i_cfg_valid <= 1'b0;
        i_cfg_index <= CFG_FRAME_WIDTH;
        i_cfg_data  <= '0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Last two settings before the final one get random sizes
        set_w[7] = $urandom_range(2, 300);
        set_h[7] = $urandom_range(1, 300);
        set_w[8] = $urandom_range(2, 2048);
        set_h[8] = $urandom_range(1, 2048);

        for (int s = 0; s < 10; s++) begin
            if (s != 0) begin
                drain();
                write_reg(CFG_FRAME_WIDTH, CFG_W'(set_w[s]));
                write_reg(CFG_FRAME_HEIGHT, CFG_W'(set_h[s]));
                write_reg(CFG_INDEXED_MODE,
                          {CFG_W'($urandom_range(0, 2047)) << 1} | CFG_W'(set_m[s]));
                i_cfg_valid <= 1'b0;
            end
            if (s == 0) begin
                // Corners, just outside, diagonals and gradient at reset size
                pixel_plan.push_back('{11'd0,    11'd0});
                pixel_plan.push_back('{11'd319,  11'd287});
                pixel_plan.push_back('{11'd319,  11'd0});
                pixel_plan.push_back('{11'd0,    11'd287});
                pixel_plan.push_back('{11'd320,  11'd0});
                pixel_plan.push_back('{11'd0,    11'd288});
                pixel_plan.push_back('{11'd2047, 11'd2047});
                pixel_plan.push_back('{11'd100,  11'd89});
                pixel_plan.push_back('{11'd100,  11'd198});
                pixel_plan.push_back('{11'd160,  11'd100});
                pixel_plan.push_back('{11'd318,  11'd286});
                pixel_plan.push_back('{11'd1,    11'd2});
                pixel_plan.push_back('{11'd1023, 11'd1024});
            end
            if (s == 5) begin
                // Fallback sum at the far corner of the largest frame
                pixel_plan.push_back('{11'd2047, 11'd2047});
                pixel_plan.push_back('{11'd0,    11'd0});
                pixel_plan.push_back('{11'd2047, 11'd0});
            end
            for (n = 0; n < RANDOM_PER_SETTING; n++) pixel_plan.push_back(pick_pixel());
            send_plan();
        end

        drain();
        if (sb.pending() != 0)
            sb.report($sformatf("%0d expected words never arrived", sb.pending()));
        $display("run: %0d pixel requests over 10 frame settings, %0d words compared",
                 pixels_sent, sb.compared);
        $display("run: sizes from zero to saturated, both pattern modes, %0d mismatches",
                 sb.mismatches);
        if (sb.mismatches == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
hdl/tvp_pkg.sv
hdl/tvp_front.sv
hdl/tvp_div_cell.sv
hdl/video_test_pattern_pixel_core.sv
sim/video_test_pattern_pixel_core_tb.sv
